// ===== hdl/u16u8_pkg.sv =====
// Shared types, constants and byte-forming functions for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] UnitBom = 16'hFEFF;
  localparam logic [20:0] CpReplace = 21'h00FFFD;
  localparam logic [5:0]  HighTag = 6'b110110;  // 0xD800 .. 0xDBFF
  localparam logic [5:0]  LowTag  = 6'b110111;  // 0xDC00 .. 0xDFFF
  localparam logic [10:0] PlaneOffset = 11'd64; // 0x10000 >> 10

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;

  // sequence length minus one
  typedef enum logic [1:0] {
    LEN_ONE   = 2'd0,
    LEN_TWO   = 2'd1,
    LEN_THREE = 2'd2,
    LEN_FOUR  = 2'd3
  } u16u8_len_e;

  // work handed from the front to the back
  typedef struct packed {
    logic            pre_fffd;
    logic            has_main;
    u16u8_len_e      main_len;
    logic [CpW-1:0]  main_cp;
  } u16u8_job_t;

  function automatic u16u8_len_e u16u8_cp_len(input logic [CpW-1:0] cp);
    u16u8_len_e len;
    if (cp <= 21'h00007F) begin
      len = LEN_ONE;
    end else if (cp <= 21'h0007FF) begin
      len = LEN_TWO;
    end else if (cp <= 21'h00FFFF) begin
      len = LEN_THREE;
    end else begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  // byte number idx of the UTF-8 sequence for cp
  function automatic logic [7:0] u16u8_byte(input logic [CpW-1:0] cp,
                                            input u16u8_len_e len,
                                            input logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] rest;
    rest = 2'(len) - idx;
    if (idx == 2'd0) begin
      case (len)
        LEN_ONE:   b = {1'b0, cp[6:0]};
        LEN_TWO:   b = LeadTwo | {3'b000, cp[10:6]};
        LEN_THREE: b = LeadThree | {4'b0000, cp[15:12]};
        LEN_FOUR:  b = LeadFour | {5'b00000, cp[20:18]};
        default:   b = 8'h00;
      endcase
    end else begin
      case (rest)
        2'd0:    b = ContMark | {2'b00, cp[5:0]};
        2'd1:    b = ContMark | {2'b00, cp[11:6]};
        2'd2:    b = ContMark | {2'b00, cp[17:12]};
        default: b = ContMark;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== hdl/u16u8_front.sv =====
// Front end: takes code units, tracks surrogate and stream-start state, builds jobs.
// Depends on u16u8_pkg.
module u16u8_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           first_byte_i,
  input  logic [7:0]           second_byte_i,
  input  logic                 final_unit_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output u16u8_pkg::u16u8_job_t job_o
);
  import u16u8_pkg::*;

  logic       little_endian_q;
  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       stream_start_q, stream_start_d;
  logic [15:0] unit;
  logic        is_high, is_low, accept;
  u16u8_job_t  job;

  // byte order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      little_endian_q <= 1'b1;
    end else if (cfg_we_i) begin
      little_endian_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // unit assembly and classification
  assign unit    = little_endian_q ? {second_byte_i, first_byte_i}
                                   : {first_byte_i, second_byte_i};
  assign is_high = (unit[15:10] == HighTag);
  assign is_low  = (unit[15:10] == LowTag);

  // job building and next state
  always_comb begin
    job            = '0;
    job.main_len   = LEN_ONE;
    held_valid_d   = held_valid_q;
    held_bits_d    = held_bits_q;
    stream_start_d = stream_start_q;
    if (accept) begin
      stream_start_d = 1'b0;
      if (stream_start_q && (unit == UnitBom)) begin
        // byte order mark dropped
      end else if (held_valid_q && is_low) begin
        held_valid_d = 1'b0;
        job.has_main = 1'b1;
        job.main_cp  = {({1'b0, held_bits_q} + PlaneOffset), unit[9:0]};
        job.main_len = LEN_FOUR;
      end else begin
        job.pre_fffd = held_valid_q;
        held_valid_d = 1'b0;
        if (is_high) begin
          if (final_unit_i) begin
            job.has_main = 1'b1;
            job.main_cp  = CpReplace;
            job.main_len = LEN_THREE;
          end else begin
            held_valid_d = 1'b1;
            held_bits_d  = unit[9:0];
          end
        end else if (is_low) begin
          job.has_main = 1'b1;
          job.main_cp  = CpReplace;
          job.main_len = LEN_THREE;
        end else begin
          job.has_main = 1'b1;
          job.main_cp  = {5'b00000, unit};
          job.main_len = u16u8_cp_len({5'b00000, unit});
        end
      end
      if (final_unit_i) begin
        held_valid_d   = 1'b0;
        stream_start_d = 1'b1;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.pre_fffd || job.has_main);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q   <= 1'b0;
      stream_start_q <= 1'b1;
    end else begin
      held_valid_q   <= held_valid_d;
      stream_start_q <= stream_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_bits_q <= held_bits_d;
  end

endmodule

// ===== hdl/u16u8_queue.sv =====
// Two-entry job queue between the front and the back.
// Depends on u16u8_pkg.
module u16u8_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u16u8_pkg::u16u8_job_t push_job_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  not_empty_o,
  output u16u8_pkg::u16u8_job_t head_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  u16u8_job_t          slot_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q, count_d;

  assign full_o      = (count_q == (PtrW+1)'(QueueDepth));
  assign not_empty_o = (count_q != '0);
  assign head_o      = slot_q[rd_ptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== hdl/u16u8_back.sv =====
// Back end: walks each job byte by byte into the output register.
// Depends on u16u8_pkg.
module u16u8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_not_empty_i,
  input  u16u8_pkg::u16u8_job_t q_head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_end_o
);
  import u16u8_pkg::*;

  logic                active_q, active_d;
  logic [CpW-1:0]      cur_cp_q, cur_cp_d;
  u16u8_len_e          cur_len_q, cur_len_d;
  logic [1:0]          idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [CpW-1:0]      pend_cp_q, pend_cp_d;
  u16u8_len_e          pend_len_q, pend_len_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                run_end_q, run_end_d;
  logic                slot_free, advance, last_byte, want_job;

  assign slot_free = !out_valid_q || out_ready_i;
  assign advance   = active_q && slot_free;
  assign last_byte = (idx_q == 2'(cur_len_q));
  assign want_job  = !active_q || (advance && last_byte && !pend_q);
  assign pop_o     = want_job && q_not_empty_i;

  // sequencing through the current job
  always_comb begin
    active_d    = active_q;
    cur_cp_d    = cur_cp_q;
    cur_len_d   = cur_len_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_cp_d   = pend_cp_q;
    pend_len_d  = pend_len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = u16u8_byte(cur_cp_q, cur_len_q, idx_q);
      run_end_d   = last_byte && !pend_q;
      idx_d       = idx_q + 2'd1;
      if (last_byte) begin
        if (pend_q) begin
          cur_cp_d  = pend_cp_q;
          cur_len_d = pend_len_q;
          idx_d     = 2'd0;
          pend_d    = 1'b0;
        end else begin
          active_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      idx_d    = 2'd0;
      if (q_head_i.pre_fffd) begin
        cur_cp_d   = CpReplace;
        cur_len_d  = LEN_THREE;
        pend_d     = q_head_i.has_main;
        pend_cp_d  = q_head_i.main_cp;
        pend_len_d = q_head_i.main_len;
      end else begin
        cur_cp_d  = q_head_i.main_cp;
        cur_len_d = q_head_i.main_len;
        pend_d    = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_cp_q   <= cur_cp_d;
    cur_len_q  <= cur_len_d;
    idx_q      <= idx_d;
    pend_cp_q  <= pend_cp_d;
    pend_len_q <= pend_len_d;
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// Path: a unit's job is written into the job queue, popped into the back end's job registers,
// then walked byte by byte into the output register. Throughput: one output byte per cycle
// from the back end's byte sequencer while the output is not stalled; a unit that makes bytes
// yields 1 to 6. The front takes one unit per cycle while the two-entry job queue has room.
// Reset: asynchronous active low; clears queue, held surrogate, sets stream start and
// little-endian byte order. Top level ties front, queue and back together.
module utf16_to_utf8_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] first_byte_i,
  input  logic [7:0] second_byte_i,
  input  logic       final_unit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);
  import u16u8_pkg::*;

  logic       q_full, q_push, q_pop, q_not_empty;
  u16u8_job_t push_job, head_job;

  // unit intake and classification
  u16u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .final_unit_i  (final_unit_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .job_o         (push_job)
  );

  // job queue
  u16u8_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_job_i  (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (head_job)
  );

  // byte emission
  u16u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (head_job),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o)
  );

endmodule

// ===== hdl/u16u8_checker.sv =====
// Port-level checks on the transcoder output stream, bound to the top level.
// Depends only on the top-level ports.
module u16u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_end_o
);

  logic out_xfer;
  logic cont_due_q;

  assign out_xfer = out_valid_o && out_ready_i;

  // a lead byte of a multi-byte sequence must be followed by a continuation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_due_q <= 1'b0;
    end else if (out_xfer) begin
      cont_due_q <= (out_byte_o[7:6] == 2'b11);
    end
  end

  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_end_o))
    else $error("output changed while stalled");

  // never a byte that UTF-8 forbids: overlong two-byte leads and F5 upwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_byte_o != 8'hC0 && out_byte_o != 8'hC1 && out_byte_o < 8'hF5)
    else $error("illegal UTF-8 byte");

  // a run never ends on a lead byte of a multi-byte sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_end_o |-> out_byte_o[7:6] != 2'b11)
    else $error("run ends inside a sequence");

  // a continuation follows every multi-byte lead
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && cont_due_q |-> out_byte_o[7:6] == 2'b10)
    else $error("missing continuation byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .run_end_o   (run_end_o)
);
